// ===== hw/rtl/bdcrt_pkg.sv =====
package bdcrt_pkg;

	localparam int NUM_SWITCHES_DEF = 8;
	localparam int MAX_SWITCHES     = 8;

	localparam int POLL_W  = 10;
	localparam int TIME_W  = 16;
	localparam int CDOWN_W = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [POLL_W-1:0]  POLL_STEP_RST   = 10'd10;
	localparam logic [TIME_W-1:0]  DEBOUNCE_RST    = 16'd50;
	localparam logic [TIME_W-1:0]  DCLICK_RST      = 16'd300;
	localparam logic               ACTIVE_LVL_RST  = 1'b1;
	localparam logic [TIME_W-1:0]  TIME_MAX        = 16'hFFFF;
	localparam logic [CDOWN_W-1:0] SUPPLY_HOLD     = 8'd200;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLL_STEP  = 2'd0,
		REG_DEBOUNCE   = 2'd1,
		REG_DCLICK     = 2'd2,
		REG_ACTIVE_LVL = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_PUSH1 = 3'd1,
		PH_REL1  = 3'd2,
		PH_PUSH2 = 3'd3,
		PH_REL2  = 3'd4
	} click_phase_t;

	typedef struct packed {
		logic [POLL_W-1:0] poll_step;
		logic [TIME_W-1:0] debounce;
		logic [TIME_W-1:0] dclick;
	} btn_cfg_t;

	typedef struct packed {
		logic push;
		logic dbl;
		logic rel;
	} btn_evt_t;

endpackage

// ===== hw/rtl/bdcrt_button.sv =====
module bdcrt_button (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  logic              raw,
	input  bdcrt_pkg::btn_cfg_t cfg,
	output bdcrt_pkg::btn_evt_t evt
);
	import bdcrt_pkg::*;

	logic              raw_last_q;
	logic              filt_q;
	logic [TIME_W-1:0] stable_q;
	click_phase_t      phase_q;

	logic              filt_d;
	logic [TIME_W-1:0] stable_d;
	logic [TIME_W:0]   sum;
	click_phase_t      phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_last_q <= 1'b0;
			filt_q     <= 1'b0;
			stable_q   <= '0;
			phase_q    <= PH_IDLE;
		end else if (tick) begin
			raw_last_q <= raw;
			filt_q     <= filt_d;
			stable_q   <= stable_d;
			phase_q    <= phase_d;
		end
	end

	always_comb begin
		sum = {1'b0, stable_q} + {{(TIME_W+1-POLL_W){1'b0}}, cfg.poll_step};
		filt_d = filt_q;
		if (raw_last_q == raw) begin
			stable_d = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
			if (stable_d >= cfg.debounce) begin
				filt_d = raw;
			end
		end else begin
			stable_d = '0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		evt     = '0;
		case (phase_q)
			PH_IDLE: begin
				if (filt_d) begin
					phase_d  = PH_PUSH1;
					evt.push = 1'b1;
				end
			end
			PH_PUSH1, PH_PUSH2: begin
				if (!filt_d) begin
					phase_d = (phase_q == PH_PUSH1) ? PH_REL1 : PH_REL2;
					evt.rel = 1'b1;
				end
			end
			PH_REL1: begin
				if (!filt_d && stable_d >= cfg.dclick) begin
					phase_d = PH_IDLE;
				end else if (filt_d) begin
					phase_d = PH_PUSH2;
					evt.dbl = 1'b1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/bdcrt_relay.sv =====
module bdcrt_relay #(
	parameter int NUM_SWITCHES = bdcrt_pkg::NUM_SWITCHES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic                    func,
	input  logic [7:0]              switch_index,
	input  logic                    switch_value,
	input  logic [NUM_SWITCHES-1:0] toggle,
	input  logic                    active_lvl,
	output logic [NUM_SWITCHES-1:0] switch_d,
	output logic [NUM_SWITCHES-1:0] relay_d,
	output logic                    supply_d
);
	import bdcrt_pkg::*;

	logic [NUM_SWITCHES-1:0] switch_q;
	logic                    supply_q;
	logic [CDOWN_W-1:0]      cdown_q;
	logic [CDOWN_W-1:0]      cdown_d;
	logic                    set_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_q <= '0;
			supply_q <= 1'b1;
			cdown_q  <= '0;
		end else if (go) begin
			switch_q <= switch_d;
			supply_q <= supply_d;
			cdown_q  <= cdown_d;
		end
	end

	always_comb begin
		switch_d = switch_q;
		supply_d = supply_q;
		cdown_d  = cdown_q;
		set_hit  = 1'b0;
		if (func) begin
			for (int i = 0; i < NUM_SWITCHES; i++) begin
				if (switch_index == 8'(i)) begin
					switch_d[i] = switch_value;
					set_hit     = 1'b1;
				end
			end
		end else begin
			// count down first, a toggle on this tick reloads
			if (cdown_q != '0) begin
				cdown_d = cdown_q - CDOWN_W'(1);
				if (cdown_d == '0) begin
					supply_d = 1'b0;
				end
			end
			switch_d = switch_q ^ toggle;
			set_hit  = |toggle;
		end
		if (set_hit) begin
			supply_d = 1'b1;
			cdown_d  = SUPPLY_HOLD;
		end
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			relay_d[i] = switch_d[i] ? active_lvl : ~active_lvl;
		end
	end

endmodule

// ===== hw/rtl/button_debounce_click_relay_toggle.sv =====
// Channel   Handshake            Payload
// s_*       s_tvalid/s_tready    tuser: func; tdata: buttons_raw, switch_index, switch_value
// m_*       m_tvalid/m_tready    tdata: relays, supply, states, push, double, release
// cfg_*     cfg_we (no wait)     cfg_index, cfg_wdata
//
// One beat per cycle sustained while m_tready stays high; a beat is held in the input register
// and its result is written into the output register once the output can take it.
// All buttons update in parallel in the single logic pass between the two.
// Reset (arst_n low) clears both registers, buttons, switches and countdown;
// supply starts high. A stalled output holds the input register, and s_tready
// drops only while both registers are full and m_tready is low.
module button_debounce_click_relay_toggle #(
	parameter int NUM_SWITCHES = bdcrt_pkg::NUM_SWITCHES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [7:0] buttons_raw, [15:8] switch_index, [16] switch_value, rest zero
	input  logic [bdcrt_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] func
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] relay_levels, [8] supply_level, [16:9] switch_states,
	// [24:17] push_mask, [32:25] double_mask, [40:33] release_mask, rest zero
	output logic [bdcrt_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                             cfg_we,
	input  logic [bdcrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdcrt_pkg::CFG_W-1:0]      cfg_wdata
);
	import bdcrt_pkg::*;

	btn_cfg_t cfg_q;
	logic     active_lvl_q;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] raw_s1;
	logic [7:0] idx_s1;
	logic       val_s1;

	logic                    go;
	logic                    tick;
	logic                    m_valid_q;
	logic [OUT_DATA_W-1:0]   m_data_q;

	logic [NUM_SWITCHES-1:0] push_v, dbl_v, rel_v;
	logic [NUM_SWITCHES-1:0] switch_d, relay_d;
	logic                    supply_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_step <= POLL_STEP_RST;
			cfg_q.debounce  <= DEBOUNCE_RST;
			cfg_q.dclick    <= DCLICK_RST;
			active_lvl_q    <= ACTIVE_LVL_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_POLL_STEP:  cfg_q.poll_step <= cfg_wdata[POLL_W-1:0];
				REG_DEBOUNCE:   cfg_q.debounce  <= cfg_wdata[TIME_W-1:0];
				REG_DCLICK:     cfg_q.dclick    <= cfg_wdata[TIME_W-1:0];
				REG_ACTIVE_LVL: active_lvl_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign go       = valid_s1 && (!m_valid_q || m_tready);
	assign tick     = go && !func_s1;
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			raw_s1  <= s_tdata[7:0];
			idx_s1  <= s_tdata[15:8];
			val_s1  <= s_tdata[16];
		end
	end

	for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_btn
		btn_evt_t evt;

		bdcrt_button u_button (
			.clk    (clk),
			.arst_n (arst_n),
			.tick   (tick),
			.raw    (raw_s1[i]),
			.cfg    (cfg_q),
			.evt    (evt)
		);

		// events only count on a tick
		assign push_v[i] = evt.push && !func_s1;
		assign dbl_v[i]  = evt.dbl && !func_s1;
		assign rel_v[i]  = evt.rel && !func_s1;
	end

	bdcrt_relay #(
		.NUM_SWITCHES (NUM_SWITCHES)
	) u_relay (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.func         (func_s1),
		.switch_index (idx_s1),
		.switch_value (val_s1),
		.toggle       (push_v | dbl_v),
		.active_lvl   (active_lvl_q),
		.switch_d     (switch_d),
		.relay_d      (relay_d),
		.supply_d     (supply_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_data_q <= {7'd0, 8'(rel_v), 8'(dbl_v), 8'(push_v), 8'(switch_d),
				supply_d, 8'(relay_d)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTH
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go |=> valid_s1 && $stable(idx_s1) && $stable(raw_s1)
			&& $stable(func_s1))
		else $error("input register changed while stalled");

	a_set_no_events: assert property (@(posedge clk) disable iff (!arst_n)
		go && func_s1 |=> m_tdata[40:17] == 24'd0)
		else $error("event mask set on a switch command");

	a_set_supply: assert property (@(posedge clk) disable iff (!arst_n)
		go && func_s1 && (idx_s1 < 8'(NUM_SWITCHES)) |=> m_tdata[8])
		else $error("supply not raised by switch command");

	a_evt_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[24:17] & m_tdata[32:25]) | (m_tdata[24:17] & m_tdata[40:33])
			| (m_tdata[32:25] & m_tdata[40:33])) == 8'd0)
		else $error("button emitted two events in one tick");
`endif

endmodule

// ===== tb/button_debounce_click_relay_toggle_test.sv =====
`timescale 1ns / 1ps

module button_debounce_click_relay_toggle_test;
	import bdcrt_pkg::*;

	localparam int N_SW        = NUM_SWITCHES_DEF;
	localparam int CYCLE_LIMIT = 200000;

	// Result fields in m_tdata order, lowest bits last in the list.
	typedef struct packed {
		logic [7:0] release_m;
		logic [7:0] dbl;
		logic [7:0] push;
		logic [7:0] states;
		logic       supply;
		logic [7:0] relays;
	} status_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// [7:0] buttons_raw, [15:8] switch_index, [16] switch_value, rest zero
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	// [0] func
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// [7:0] relay_levels, [8] supply_level, [16:9] switch_states,
	// [24:17] push_mask, [32:25] double_mask, [40:33] release_mask, rest zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	button_debounce_click_relay_toggle #(
		.NUM_SWITCHES(N_SW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Panel state as the block should hold it
	logic [POLL_W-1:0]  step_ms;
	logic [TIME_W-1:0]  deb_ms;
	logic [TIME_W-1:0]  dc_ms;
	logic               on_level;
	logic [7:0]         raw_last;
	logic [7:0]         filt;
	logic [7:0]         sw_on;
	logic [TIME_W-1:0]  stable_t [MAX_SWITCHES];
	click_phase_t       phase [MAX_SWITCHES];
	logic               supply_on;
	logic [CDOWN_W-1:0] countdown;

	status_t status_due [$];
	status_t got_st;
	status_t want_st;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int n_sent         = 0;
	int n_checked      = 0;
	int n_errors       = 0;
	int cycles         = 0;

	initial forever #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				status_due.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic void reset_panel();
		int i;
		step_ms   = POLL_STEP_RST;
		deb_ms    = DEBOUNCE_RST;
		dc_ms     = DCLICK_RST;
		on_level  = ACTIVE_LVL_RST;
		raw_last  = '0;
		filt      = '0;
		sw_on     = '0;
		supply_on = 1'b1;
		countdown = '0;
		for (i = 0; i < MAX_SWITCHES; i++) begin
			stable_t[i] = '0;
			phase[i]    = PH_IDLE;
		end
	endfunction

	// Any switch write raises the supply and restarts its hold time.
	function automatic void drive_switch(int i, logic v);
		supply_on = 1'b1;
		countdown = SUPPLY_HOLD;
		sw_on[i]  = v;
	endfunction

	function automatic status_t compute_status(logic func, logic [7:0] raw, logic [7:0] idx,
			logic v);
		status_t s;
		logic    f;
		int      t;
		int      i;
		s = '0;
		if (func) begin
			if (idx < N_SW)
				drive_switch(int'(idx), v);
		end else begin
			if (countdown != 0) begin
				countdown--;
				if (countdown == 0)
					supply_on = 1'b0;
			end
			for (i = 0; i < N_SW; i++) begin
				if (raw_last[i] == raw[i]) begin
					t = int'(stable_t[i]) + int'(step_ms);
					stable_t[i] = (t > int'(TIME_MAX)) ? TIME_MAX : t[TIME_W-1:0];
					if (stable_t[i] >= deb_ms)
						filt[i] = raw[i];
				end else begin
					stable_t[i] = '0;
				end
				raw_last[i] = raw[i];
				f = filt[i];
				case (phase[i])
					PH_IDLE: begin
						if (f) begin
							phase[i]  = PH_PUSH1;
							s.push[i] = 1'b1;
							drive_switch(i, ~sw_on[i]);
						end
					end
					PH_PUSH1: begin
						if (!f) begin
							phase[i]       = PH_REL1;
							s.release_m[i] = 1'b1;
						end
					end
					PH_REL1: begin
						if (!f && stable_t[i] >= dc_ms) begin
							phase[i] = PH_IDLE;
						end else if (f) begin
							phase[i] = PH_PUSH2;
							s.dbl[i] = 1'b1;
							drive_switch(i, ~sw_on[i]);
						end
					end
					PH_PUSH2: begin
						if (!f) begin
							phase[i]       = PH_REL2;
							s.release_m[i] = 1'b1;
						end
					end
					// second release and stray codes fall back to idle
					default: phase[i] = PH_IDLE;
				endcase
			end
		end
		for (i = 0; i < N_SW; i++) begin
			s.relays[i] = sw_on[i] ? on_level : ~on_level;
			s.states[i] = sw_on[i];
		end
		s.supply = supply_on;
		return s;
	endfunction

	function automatic void flag_error(string what, status_t want, status_t got);
		n_errors++;
		if (n_errors <= 10) begin
			$display("%s: want relays=%h supply=%b states=%h push=%h dbl=%h rel=%h",
				what, want.relays, want.supply, want.states, want.push, want.dbl,
				want.release_m);
			$display("%s:  got relays=%h supply=%b states=%h push=%h dbl=%h rel=%h",
				what, got.relays, got.supply, got.states, got.push, got.dbl,
				got.release_m);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_st = m_tdata[40:0];
			n_checked++;
			if (status_due.size() == 0) begin
				flag_error("unexpected beat", '0, got_st);
			end else begin
				want_st = status_due.pop_front();
				if (got_st.relays !== want_st.relays || got_st.supply !== want_st.supply ||
						got_st.states !== want_st.states || got_st.push !== want_st.push ||
						got_st.dbl !== want_st.dbl || got_st.release_m !== want_st.release_m)
					flag_error($sformatf("beat %0d", n_checked), want_st, got_st);
			end
		end
	end

	task automatic send_item(logic func, logic [7:0] raw, logic [7:0] idx, logic v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {7'd0, v, idx, raw};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		status_due.push_back(compute_status(func, raw, idx, v));
		n_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic set_config(logic [POLL_W-1:0] step, logic [TIME_W-1:0] deb,
			logic [TIME_W-1:0] dc, logic lvl);
		write_reg(REG_POLL_STEP, CFG_W'(step));
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_DCLICK, dc);
		write_reg(REG_ACTIVE_LVL, CFG_W'(lvl));
		cfg_we   <= 1'b0;
		step_ms  = step;
		deb_ms   = deb;
		dc_ms    = dc;
		on_level = lvl;
		@(posedge clk);
	endtask

	task automatic set_idle(int send_pct, int stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	// Reset config: idle supply tick, every switch on, ignored indexes, two switches off, then a
	// held push on all buttons and a release too short to pass the debounce.
	task automatic test_directed();
		int i;
		send_item(1'b0, 8'h00, 8'h00, 1'b0);
		for (i = 0; i < N_SW; i++)
			send_item(1'b1, 8'h00, 8'(i), 1'b1);
		send_item(1'b1, 8'hFF, 8'd8, 1'b0);
		send_item(1'b1, 8'h00, 8'hFF, 1'b0);
		send_item(1'b1, 8'h00, 8'd7, 1'b0);
		send_item(1'b1, 8'h00, 8'd0, 1'b0);
		repeat (7) send_item(1'b0, 8'hFF, 8'h00, 1'b0);
		repeat (2) send_item(1'b0, 8'h00, 8'hFF, 1'b1);
	endtask

	// Each button holds a level for a random number of ticks, with short
	// bounces mixed in; a few beats are noise or switch commands.
	task automatic test_click_sequences(int n, int hold_max, int set_pct);
		logic [7:0] lvl;
		logic [7:0] idx;
		int         hold [MAX_SWITCHES];
		int         k;
		int         i;
		lvl = '0;
		for (i = 0; i < MAX_SWITCHES; i++)
			hold[i] = $urandom_range(1, hold_max);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < set_pct) begin
				idx = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(N_SW, 255))
					: 8'($urandom_range(0, N_SW - 1));
				send_item(1'b1, 8'($urandom), idx, 1'($urandom));
			end else if ($urandom_range(0, 99) < 6) begin
				send_item(1'b0, 8'($urandom), 8'($urandom), 1'($urandom));
			end else begin
				for (i = 0; i < MAX_SWITCHES; i++) begin
					if (hold[i] == 0) begin
						lvl[i]  = ~lvl[i];
						hold[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
							: $urandom_range(1, hold_max);
					end else begin
						hold[i]--;
					end
				end
				send_item(1'b0, lvl, 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// Hold all buttons released long enough for the supply to time out.
	task automatic test_supply_timeout();
		send_item(1'b1, 8'h00, 8'd3, 1'b1);
		repeat (230) send_item(1'b0, 8'h00, 8'h00, 1'b0);
		send_item(1'b1, 8'h00, 8'd2, 1'b0);
		send_item(1'b0, 8'h00, 8'h00, 1'b0);
	endtask

	initial begin
		reset_panel();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(0, 0);
		test_directed();
		drain();

		set_config(10'd10, 16'd20, 16'd60, 1'b1);
		test_click_sequences(250, 12, 8);
		drain();

		set_config(10'd1, 16'd0, 16'd0, 1'b0);
		set_idle(77, 0);
		test_click_sequences(200, 4, 8);
		drain();

		set_config(10'd1000, 16'hFFFF, 16'hFFFF, 1'b1);
		set_idle(0, 77);
		test_click_sequences(250, 140, 3);
		drain();

		set_config(10'd7, 16'd30, 16'd100, 1'b0);
		set_idle(10, 10);
		test_click_sequences(150, 24, 6);
		drain();

		set_config(10'd5, 16'd10, 16'd20, 1'b1);
		set_idle(77, 0);
		test_supply_timeout();
		drain();
		repeat (10) @(posedge clk);

		$display("run covered %0d beats: directed, click runs at four settings, supply timeout",
			n_sent);
		$display("%0d results checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0 && status_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
